[rtl/core/dht_single_wire_receiver_top_assert.svh]
// Assertion macros for the single-wire sensor receiver.
`ifndef DHT_SINGLE_WIRE_RECEIVER_TOP_ASSERT_SVH
`define DHT_SINGLE_WIRE_RECEIVER_TOP_ASSERT_SVH

// A condition that must never hold while out of reset.
`define DHTSWR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define DHTSWR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define DHTSWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dhtswr_pkg.sv]
// Types and constants shared by the single-wire sensor receiver.
package dhtswr_pkg;

  localparam int FRAME_WINDOW    = 40;
  localparam int FIRST_DATA_EDGE = 4;
  localparam int HUM_LIMIT       = 1000;
  localparam int TEMP_LIMIT      = 1250;
  localparam int CFG_WIDTH       = 8;

  localparam logic       OP_START = 1'b0;
  localparam logic       OP_TICK  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

  localparam logic       CFG_BIT_THRESHOLD = 1'b0;
  localparam logic       CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [CFG_WIDTH-1:0] BIT_THRESHOLD_RESET = 8'd16;
  localparam logic [CFG_WIDTH-1:0] TIMEOUT_TICKS_RESET = 8'd255;

  typedef struct packed {
    logic op;
    logic line_level;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] humidity_tenths;
    logic [15:0] temperature_tenths;
  } out_word_t;

  // A finished read: the first forty bits and whether all forty arrived.
  typedef struct packed {
    logic                    complete;
    logic [FRAME_WINDOW-1:0] bits;
  } frame_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } fifo_stat_t;

endpackage

[rtl/core/dhtswr_front.sv]
// Front end: counts line levels per tick, decodes bits and emits finished frames.
module dhtswr_front import dhtswr_pkg::*; #(
  parameter int MAX_EDGES  = 85,
  parameter int FRAME_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  in_word_t             in_word,
  input  logic [CFG_WIDTH-1:0] bit_threshold,
  input  logic [CFG_WIDTH-1:0] timeout_ticks,
  output logic                 push,
  output frame_t               push_frame
);

  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int BW = $clog2(FRAME_BITS + 1);

  logic                    busy, busy_next;
  logic                    last_level, last_level_next;
  logic [7:0]              tick_count, tick_count_next;
  logic [EW-1:0]           edge_count, edge_count_next;
  logic [BW-1:0]           bit_count, bit_count_next;
  logic [FRAME_WINDOW-1:0] window, window_next;

  logic [8:0]    tick_inc;
  logic [EW-1:0] edge_inc;
  logic          data_edge;
  logic          bit_value;

  always_comb begin
    busy_next       = busy;
    last_level_next = last_level;
    tick_count_next = tick_count;
    edge_count_next = edge_count;
    bit_count_next  = bit_count;
    window_next     = window;
    push            = 1'b0;
    tick_inc        = {1'b0, tick_count} + 9'd1;
    edge_inc        = edge_count + EW'(1);
    data_edge       = (edge_count >= EW'(FIRST_DATA_EDGE)) && !edge_count[0]
                      && (bit_count < BW'(FRAME_BITS));
    bit_value       = tick_count > bit_threshold;
    if (accept) begin
      if (in_word.op == OP_START) begin
        busy_next       = 1'b1;
        last_level_next = 1'b1;
        tick_count_next = 8'd0;
        edge_count_next = '0;
        bit_count_next  = '0;
        window_next     = '0;
      end else if (busy) begin
        if (in_word.line_level == last_level) begin
          tick_count_next = tick_inc[7:0];
          // A wrap of the tick counter also ends the read.
          if (tick_inc[8] || (tick_inc[7:0] >= timeout_ticks)) begin
            push      = 1'b1;
            busy_next = 1'b0;
          end
        end else begin
          if (data_edge) begin
            bit_count_next = bit_count + BW'(1);
            // Only the first forty bits form the frame; later ones are only counted.
            if (7'(bit_count) < 7'(FRAME_WINDOW)) begin
              window_next = {window[FRAME_WINDOW-2:0], bit_value};
            end
          end
          edge_count_next = edge_inc;
          last_level_next = in_word.line_level;
          tick_count_next = 8'd0;
          if (edge_inc >= EW'(MAX_EDGES)) begin
            push      = 1'b1;
            busy_next = 1'b0;
          end
        end
      end
    end
    push_frame.complete = 7'(bit_count_next) >= 7'(FRAME_WINDOW);
    push_frame.bits     = window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      last_level <= 1'b1;
      tick_count <= 8'd0;
      edge_count <= '0;
      bit_count  <= '0;
    end else begin
      busy       <= busy_next;
      last_level <= last_level_next;
      tick_count <= tick_count_next;
      edge_count <= edge_count_next;
      bit_count  <= bit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    window <= window_next;
  end

endmodule

[rtl/core/dhtswr_fifo.sv]
// Two-entry queue of finished frames between the front and back ends.
module dhtswr_fifo import dhtswr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_t     push_frame,
  input  logic       pop,
  output frame_t     head,
  output fifo_stat_t stat
);

  frame_t     entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head          = entries[rd_ptr];
  assign stat.full     = count == 2'd2;
  assign stat.nonempty = count != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule

[rtl/core/dhtswr_back.sv]
// Back end: checks the frame checksum, scales the readings and holds the result word.
module dhtswr_back import dhtswr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      frame_valid,
  input  frame_t    frame,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic [7:0]  b0, b1, b2, b3, b4;
  logic [7:0]  sum;
  logic [15:0] hum_raw, temp_raw;
  logic [15:0] hum_dht11, temp_dht11;
  out_word_t   result;

  always_comb begin
    b0         = frame.bits[39:32];
    b1         = frame.bits[31:24];
    b2         = frame.bits[23:16];
    b3         = frame.bits[15:8];
    b4         = frame.bits[7:0];
    sum        = b0 + b1 + b2 + b3;
    hum_raw    = {b0, b1};
    temp_raw   = {b2, b3};
    // Times ten as a sum of two shifts.
    hum_dht11  = {5'd0, b0, 3'd0} + {7'd0, b0, 1'b0};
    temp_dht11 = {5'd0, b2, 3'd0} + {7'd0, b2, 1'b0};
    result     = '0;
    if (!frame.complete) begin
      result.status = STATUS_SHORT;
    end else if (sum != b4) begin
      result.status = STATUS_CHECKSUM;
    end else begin
      result.status             = STATUS_OK;
      result.humidity_tenths    = (hum_raw > 16'(HUM_LIMIT)) ? hum_dht11 : hum_raw;
      result.temperature_tenths = (temp_raw > 16'(TEMP_LIMIT)) ? temp_dht11 : temp_raw;
    end
  end

  assign pop = frame_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= result;
    end
  end

endmodule

[rtl/core/dht_single_wire_receiver_top.sv]
// Single-wire sensor receiver: one line sample per cycle in, one reading per finished read.
// Throughput: one input word every cycle while in_stall is low; stall rises only while both queue entries are full.
// Path: a reading passes from the sample that ends the read through the queue into the result register.
// Synchronous active-high reset: idle, line assumed high, registers at 16 and 255, queue empty.
// The result register lets the front keep sampling while a reading waits to be taken.
module dht_single_wire_receiver_top import dhtswr_pkg::*; #(
  parameter int MAX_EDGES  = 85,
  parameter int FRAME_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  `include "dht_single_wire_receiver_top_assert.svh"

  logic [CFG_WIDTH-1:0] bit_threshold;
  logic [CFG_WIDTH-1:0] timeout_ticks;
  logic                 accept;
  logic                 push;
  logic                 pop;
  frame_t               push_frame;
  frame_t               head;
  fifo_stat_t           stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold <= BIT_THRESHOLD_RESET;
      timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BIT_THRESHOLD: bit_threshold <= cfg_data;
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default:           bit_threshold <= bit_threshold;
      endcase
    end
  end

  assign in_stall = stat.full;
  assign accept   = in_valid && !in_stall;

  dhtswr_front #(
    .MAX_EDGES (MAX_EDGES),
    .FRAME_BITS(FRAME_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_word      (in_word),
    .bit_threshold(bit_threshold),
    .timeout_ticks(timeout_ticks),
    .push         (push),
    .push_frame   (push_frame)
  );

  dhtswr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_frame(push_frame),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  dhtswr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .frame_valid(stat.nonempty),
    .frame      (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  `DHTSWR_ASSERT_NEVER(a_no_push_when_full, push && stat.full, "frame pushed into a full queue")
  `DHTSWR_ASSERT_IMPLY(a_failed_read_zero,
      out_valid && (out_word.status != STATUS_OK),
      (out_word.humidity_tenths == 16'd0) && (out_word.temperature_tenths == 16'd0),
      "failed read carries a nonzero reading")
  `DHTSWR_ASSERT_NEXT(a_pop_fills_output, pop, out_valid, "popped frame did not reach the output")

endmodule
